// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/ivsc_pkg.sv =====
// Types, codes and constants of the idle valve stepper controller.
package ivsc_pkg;

	localparam int CMD_W = 3;
	localparam int POS_W = 16;
	localparam int PER_W = 26;
	localparam int DB_W = 10;
	localparam int RPM_W = 14;
	localparam int IN_TDATA_W = 48;
	localparam int OUT_TDATA_W = 24;
	localparam int ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STEP_FWD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STEP_BACK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MOVE_TO = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CALIBRATE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REGULATE = 3'd5;

	// Register indexes (word address)
	localparam logic [1:0] REG_TOTAL_STEPS = 2'd0;
	localparam logic [1:0] REG_STEP_PERIOD = 2'd1;
	localparam logic [1:0] REG_RPM_DEADBAND = 2'd2;

	// Register reset values
	localparam logic [POS_W-1:0] TOTAL_STEPS_RST = 16'd200;
	localparam logic [PER_W-1:0] STEP_PERIOD_RST = 26'd64000;
	localparam logic [DB_W-1:0] RPM_DEADBAND_RST = 10'd40;

	typedef struct packed {
		logic [POS_W-1:0] total_steps;
		logic [PER_W-1:0] step_period;
		logic [DB_W-1:0]  rpm_deadband;
	} cfg_t;

	// Input item, first field in the highest bits
	typedef struct packed {
		logic [RPM_W-1:0] rpm_setpoint;
		logic [RPM_W-1:0] measured_rpm;
		logic [POS_W-1:0] target_position;
		logic [CMD_W-1:0] command;
	} item_t;

	// Result item, first field in the highest bits
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             busy_res;
		logic             direction;
		logic             step_pulse;
	} result_t;

endpackage

// ===== rtl/core/ivsc_regs.sv =====
// APB configuration registers of the idle valve stepper controller.
module ivsc_regs import ivsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	// Write the addressed register; addresses past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_steps <= TOTAL_STEPS_RST;
			cfg_q.step_period <= STEP_PERIOD_RST;
			cfg_q.rpm_deadband <= RPM_DEADBAND_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_TOTAL_STEPS:  cfg_q.total_steps <= pwdata[POS_W-1:0];
				REG_STEP_PERIOD:  cfg_q.step_period <= pwdata[PER_W-1:0];
				REG_RPM_DEADBAND: cfg_q.rpm_deadband <= pwdata[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[3:2])
			REG_TOTAL_STEPS:  prdata = {{(APB_DATA_W-POS_W){1'b0}}, cfg_q.total_steps};
			REG_STEP_PERIOD:  prdata = {{(APB_DATA_W-PER_W){1'b0}}, cfg_q.step_period};
			REG_RPM_DEADBAND: prdata = {{(APB_DATA_W-DB_W){1'b0}}, cfg_q.rpm_deadband};
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/ivsc_core.sv =====
// Input stage, motion state update and result register of the controller.
module ivsc_core import ivsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	input  item_t   in_item,
	output logic    in_ready,
	output logic    out_valid,
	output result_t out_result,
	input  logic    out_ready
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MOVE,
		PH_CAL_FWD,
		PH_CAL_BACK
	} phase_t;

	// Input stage
	logic  valid_s1;
	item_t item_s1;

	// Motion state
	logic [POS_W-1:0] valve_pos_q, goal_pos_q, steps_left_q;
	logic [PER_W-1:0] tick_q;
	logic             dir_q;
	phase_t           phase_q;

	// Result register
	logic    out_valid_q;
	result_t result_q;

	// Next state
	logic [POS_W-1:0] valve_pos_n, goal_pos_n, steps_left_n, sl_dec;
	logic [PER_W-1:0] tick_n, tick_inc, period;
	logic             dir_n, pulse, busy, step_fwd, step_back;
	logic             rpm_low, rpm_high;
	logic [RPM_W:0]   meas_ext, trpm_ext, db_ext;
	phase_t           phase_n;
	logic             advance, process;

	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign process = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign out_result = result_q;

	// Compute the state after the held item
	always_comb begin
		valve_pos_n = valve_pos_q;
		goal_pos_n = goal_pos_q;
		steps_left_n = steps_left_q;
		tick_n = tick_q;
		dir_n = dir_q;
		phase_n = phase_q;
		pulse = 1'b0;
		step_fwd = 1'b0;
		step_back = 1'b0;

		busy = (phase_q != PH_IDLE);
		period = (cfg.step_period == '0) ? {{(PER_W-1){1'b0}}, 1'b1} : cfg.step_period;
		tick_inc = tick_q + 1'b1;
		sl_dec = (steps_left_q != '0) ? steps_left_q - 1'b1 : steps_left_q;

		meas_ext = {1'b0, item_s1.measured_rpm};
		trpm_ext = {1'b0, item_s1.rpm_setpoint};
		db_ext = {{(RPM_W+1-DB_W){1'b0}}, cfg.rpm_deadband};
		rpm_low = (meas_ext + db_ext) < trpm_ext;
		rpm_high = meas_ext > (trpm_ext + db_ext);

		case (item_s1.command)
			CMD_TICK: begin
				if (busy) begin
					tick_n = tick_inc;
					if (tick_inc >= period) begin
						tick_n = '0;
						pulse = 1'b1;
						steps_left_n = sl_dec;
						if (sl_dec == '0) begin
							case (phase_q)
								PH_CAL_FWD: begin
									dir_n = 1'b0;
									steps_left_n = cfg.total_steps;
									if (cfg.total_steps == '0) begin
										valve_pos_n = '0;
										phase_n = PH_IDLE;
									end else begin
										phase_n = PH_CAL_BACK;
									end
								end
								PH_CAL_BACK: begin
									valve_pos_n = '0;
									phase_n = PH_IDLE;
								end
								default: begin
									valve_pos_n = goal_pos_q;
									phase_n = PH_IDLE;
								end
							endcase
						end
					end
				end
			end
			CMD_STEP_FWD: begin
				if (!busy) begin
					pulse = 1'b1;
					step_fwd = 1'b1;
				end
			end
			CMD_STEP_BACK: begin
				if (!busy) begin
					pulse = 1'b1;
					step_back = 1'b1;
				end
			end
			CMD_MOVE_TO: begin
				if (!busy && item_s1.target_position != valve_pos_q) begin
					if (item_s1.target_position > valve_pos_q) begin
						steps_left_n = item_s1.target_position - valve_pos_q;
						dir_n = 1'b1;
					end else begin
						steps_left_n = valve_pos_q - item_s1.target_position;
						dir_n = 1'b0;
					end
					goal_pos_n = item_s1.target_position;
					tick_n = '0;
					phase_n = PH_MOVE;
				end
			end
			CMD_CALIBRATE: begin
				if (!busy) begin
					dir_n = 1'b1;
					tick_n = '0;
					steps_left_n = cfg.total_steps;
					if (cfg.total_steps == '0) begin
						valve_pos_n = '0;
					end else begin
						phase_n = PH_CAL_FWD;
					end
				end
			end
			CMD_REGULATE: begin
				if (!busy) begin
					if (rpm_low) begin
						pulse = 1'b1;
						step_fwd = 1'b1;
					end else if (rpm_high) begin
						pulse = 1'b1;
						step_back = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// Single step, saturating between zero and the full travel
		if (step_fwd && valve_pos_q < cfg.total_steps) begin
			valve_pos_n = valve_pos_q + 1'b1;
			dir_n = 1'b1;
		end
		if (step_back && valve_pos_q != '0) begin
			valve_pos_n = valve_pos_q - 1'b1;
			dir_n = 1'b0;
		end
	end

	// Control state: input valid, motion state, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			valve_pos_q <= '0;
			goal_pos_q <= '0;
			steps_left_q <= '0;
			tick_q <= '0;
			dir_q <= 1'b0;
			phase_q <= PH_IDLE;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (process) begin
				out_valid_q <= 1'b1;
				valve_pos_q <= valve_pos_n;
				goal_pos_q <= goal_pos_n;
				steps_left_q <= steps_left_n;
				tick_q <= tick_n;
				dir_q <= dir_n;
				phase_q <= phase_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold the accepted item, capture the result
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (process) begin
			result_q.step_pulse <= pulse;
			result_q.direction <= dir_n;
			result_q.busy_res <= (phase_n != PH_IDLE);
			result_q.position <= valve_pos_n;
		end
	end

endmodule

// ===== rtl/core/idle_valve_stepper_controller.sv =====
// An accepted transaction is held in the input stage, then loads the result register when
// that register is empty or being taken, raising m_tvalid (input stage, result stage).
// One transaction per cycle unless m_tready stalls; the tick is a 26-bit add and compare.
// s_tready stays high while the result register is empty or being taken.
// Reset (arst_n low): position, goal, step count, tick count, direction and phase go to zero;
// registers return to total_steps 200, step_period 64000, rpm_deadband 40.
module idle_valve_stepper_controller import ivsc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// command[2:0], target_position[18:3], measured_rpm[32:19], rpm_setpoint[46:33], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// step_pulse[0], direction[1], busy_res[2], position[18:3], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	cfg_t    cfg;
	item_t   in_item;
	result_t out_result;

	assign in_item = s_tdata[$bits(item_t)-1:0];
	assign m_tdata = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, out_result};

	ivsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ivsc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_item    (in_item),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_result (out_result),
		.out_ready  (m_tready)
	);

endmodule

// ===== rtl/core/ivsc_checker.sv =====
// Port-level checker of the idle valve stepper controller, bound to the top level.
`include "assert_macros.svh"

module ivsc_checker import ivsc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready
);

	logic             out_xfer;
	logic             last_busy_q;
	logic [POS_W-1:0] last_pos_q;

	assign out_xfer = m_tvalid && m_tready;

	// Track the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_busy_q <= 1'b0;
			last_pos_q <= '0;
		end else if (out_xfer) begin
			last_busy_q <= m_tdata[2];
			last_pos_q <= m_tdata[18:3];
		end
	end

	`ASSERT_CLK(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")
	`ASSERT_IMPLY(a_in_ready_free, !m_tvalid, s_tready, "input stalled with empty result register")
	`ASSERT_IMPLY(a_busy_pos, out_xfer && last_busy_q && m_tdata[2], m_tdata[18:3] == last_pos_q, "position moved during a move")
	`ASSERT_IMPLY(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_W-1:19] == '0, "result pad bits not zero")

endmodule

bind idle_valve_stepper_controller ivsc_checker u_ivsc_checker (.*);
